FILE: hdl/adaptive_column_encode_selector_assert.svh
// Assertion macros for the adaptive column encode selector.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef ADAPTIVE_COLUMN_ENCODE_SELECTOR_ASSERT_SVH
`define ADAPTIVE_COLUMN_ENCODE_SELECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define ACS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ACS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ACS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/acs_pkg.sv
// Shared constants, types and helpers of the adaptive column encode selector.
// No dependencies; used by acs_mod and the top level.
`default_nettype none

package acs_pkg;

  localparam int COLUMNS  = 32;
  localparam int SUM_BITS = 48;

  localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CCOUNT_W = 7;
  localparam int CNT_W    = $clog2(COLUMNS + 1);
  localparam int IN_COL_W = 6;
  localparam int BYTE_W   = 32;
  localparam int LVL_W    = 8;
  localparam int SMP_W    = 16;
  localparam int LIM_W    = 16;
  localparam int CFG_W    = 30;
  localparam int IDX_W    = 3;
  localparam int CC_W     = 64;
  localparam int PER_W    = 31;
  localparam int DIV_CNT_W = $clog2(CC_W);
  localparam int SPLIT    = SUM_BITS / 2;
  localparam int PLO_W    = SPLIT + LIM_W;
  localparam int PHI_W    = SUM_BITS - SPLIT + LIM_W;
  localparam int PROD_W   = SUM_BITS + LIM_W;

  localparam logic [PER_W-1:0]    PERIOD_CAP   = PER_W'(1000000000);
  localparam logic [LVL_W-1:0]    RST_SESSION  = LVL_W'(1);
  localparam logic [SMP_W-1:0]    RST_SAMPLE   = SMP_W'(5);
  localparam logic [LIM_W-1:0]    RST_LIMIT    = LIM_W'(58982);
  localparam logic [PER_W-1:0]    RST_PERIOD   = PER_W'(64);
  localparam logic [CCOUNT_W-1:0] RST_COLCOUNT = CCOUNT_W'(1);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CHUNK  = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_SESSION_LEVEL  = 3'd0,
    REG_SAMPLE_COUNT   = 3'd1,
    REG_RATIO_LIMIT    = 3'd2,
    REG_INITIAL_PERIOD = 3'd3,
    REG_COLUMN_COUNT   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SAMP,
    S_MUL,
    S_OUT
  } acs_state_t;

  typedef struct packed {
    logic [LVL_W-1:0]    level;
    logic [SUM_BITS-1:0] raw;
    logic [SUM_BITS-1:0] coded;
  } acs_entry_t;

  typedef struct packed {
    logic             start;
    logic [CC_W-1:0]  dividend;
    logic [PER_W-1:0] divisor;
  } acs_mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PER_W-1:0] rem;
  } acs_mod_rsp_t;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + (SUM_BITS + 1)'(b);
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/acs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/acs_mod.sv
// Bit-serial remainder unit: chunk count modulo sampling period, one bit per cycle.
// Depends on acs_pkg.
`default_nettype none

module acs_mod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  acs_pkg::acs_mod_req_t req,
  output acs_pkg::acs_mod_rsp_t rsp
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [acs_pkg::DIV_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [acs_pkg::CC_W-1:0]            dvd_r, dvd_nxt;
  logic [acs_pkg::PER_W-1:0]           dsr_r, dsr_nxt;
  logic [acs_pkg::PER_W-1:0]           rem_r, rem_nxt;
  logic [acs_pkg::PER_W:0]             trial;
  logic [acs_pkg::PER_W:0]             diff;

  always_comb begin
    trial    = {rem_r, dvd_r[acs_pkg::CC_W-1]};
    diff     = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[acs_pkg::PER_W-1:0]
                                         : trial[acs_pkg::PER_W-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + acs_pkg::DIV_CNT_W'(1);
      if (cnt_r == acs_pkg::DIV_CNT_W'(acs_pkg::CC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r || done_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

FILE: hdl/adaptive_column_encode_selector.sv
// Top level of the adaptive column encode selector: control, handshakes, config.
// Depends on acs_pkg, acs_ram, acs_mod and the assertion macro header.
//
// A sample item reads its entry and then writes back the saturating update;
// a sample that falls outside the sampling window, hits an unused column or
// arrives with adaptation off is dropped. An end-of-chunk item starts the walk
// by reading the first entry, then takes each column in use through S_MUL
// (ratio product) and S_OUT (comparison, report and next entry read), and it
// waits in S_OUT while the result side stalls. Column levels and byte sums
// live in one 32-entry RAM; per-entry valid bits stand in for reset and
// session-level reloads, so no clearing pass runs. When an adjustment doubles
// the period, or initial_period is written, the input stalls while a
// one-bit-per-cycle remainder unit recomputes the chunk phase.
`default_nettype none
`include "adaptive_column_encode_selector_assert.svh"

module adaptive_column_encode_selector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [acs_pkg::IDX_W-1:0]        cfg_index,
  input  logic [acs_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [acs_pkg::IN_COL_W-1:0]     in_column,
  input  logic [acs_pkg::BYTE_W-1:0]       in_raw_bytes,
  input  logic [acs_pkg::BYTE_W-1:0]       in_coded_bytes,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [acs_pkg::IN_COL_W-1:0]     out_column,
  output logic [acs_pkg::LVL_W-1:0]        out_level,
  output logic                             out_last
);

  acs_pkg::acs_state_t                state_r, state_nxt;
  logic [acs_pkg::LVL_W-1:0]          session_r, session_nxt;
  logic [acs_pkg::SMP_W-1:0]          sample_r, sample_nxt;
  logic [acs_pkg::LIM_W-1:0]          limit_r, limit_nxt;
  logic [acs_pkg::CCOUNT_W-1:0]       colcnt_r, colcnt_nxt;
  logic [acs_pkg::PER_W-1:0]          period_r, period_nxt;
  logic [acs_pkg::PER_W-1:0]          phase_r, phase_nxt;
  logic [acs_pkg::CC_W-1:0]           chunk_r, chunk_nxt;
  logic [acs_pkg::COLUMNS-1:0]        lvl_vld_r, lvl_vld_nxt;
  logic [acs_pkg::COLUMNS-1:0]        sum_vld_r, sum_vld_nxt;
  logic [acs_pkg::COL_W-1:0]          addr_r, addr_nxt;
  logic                               adj_r, adj_nxt;
  logic                               out_valid_r, out_valid_nxt;

  logic [acs_pkg::BYTE_W-1:0]         smp_raw_r, smp_raw_nxt;
  logic [acs_pkg::BYTE_W-1:0]         smp_coded_r, smp_coded_nxt;
  logic [acs_pkg::PLO_W-1:0]          p_lo_r, p_lo_nxt;
  logic [acs_pkg::PHI_W-1:0]          p_hi_r, p_hi_nxt;
  logic [acs_pkg::IN_COL_W-1:0]       out_column_r, out_column_nxt;
  logic [acs_pkg::LVL_W-1:0]          out_level_r, out_level_nxt;
  logic                               out_last_r, out_last_nxt;

  logic                               ram_we, ram_re;
  logic [acs_pkg::COL_W-1:0]          ram_waddr, ram_raddr;
  acs_pkg::acs_entry_t                ram_wdata, ram_rdata;

  acs_pkg::acs_mod_req_t              mod_req;
  acs_pkg::acs_mod_rsp_t              mod_rsp;

  logic [acs_pkg::CNT_W-1:0]          n_eff;
  logic                               adapt_on, in_acc, in_col_ok, in_window, adj_now;
  logic [acs_pkg::PER_W-1:0]          ph1, ph_wrap;
  logic [acs_pkg::LVL_W-1:0]          lvl_eff;
  logic [acs_pkg::SUM_BITS-1:0]       raw_eff, coded_eff;
  logic [acs_pkg::PROD_W-1:0]         lhs, rhs;
  logic                               below, walk_last;

  acs_ram #(
    .WIDTH ($bits(acs_pkg::acs_entry_t)),
    .DEPTH (acs_pkg::COLUMNS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  acs_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  always_comb begin
    if (colcnt_r == '0) begin
      n_eff = acs_pkg::CNT_W'(1);
    end else if (colcnt_r > acs_pkg::CCOUNT_W'(acs_pkg::COLUMNS)) begin
      n_eff = acs_pkg::CNT_W'(acs_pkg::COLUMNS);
    end else begin
      n_eff = colcnt_r[acs_pkg::CNT_W-1:0];
    end
  end

  assign adapt_on  = session_r[0] && (|session_r[acs_pkg::LVL_W-1:1]);
  assign in_stall  = (state_r != acs_pkg::S_IDLE) || mod_rsp.busy;
  assign in_acc    = in_valid && !in_stall;
  assign in_col_ok = acs_pkg::CCOUNT_W'(in_column) < acs_pkg::CCOUNT_W'(n_eff);
  assign in_window = phase_r < acs_pkg::PER_W'(sample_r);
  assign ph1       = phase_r + acs_pkg::PER_W'(1);
  assign ph_wrap   = (ph1 == period_r) ? '0 : ph1;
  assign adj_now   = adapt_on && (ph_wrap == acs_pkg::PER_W'(sample_r));

  assign lvl_eff   = lvl_vld_r[addr_r] ? ram_rdata.level : session_r;
  assign raw_eff   = sum_vld_r[addr_r] ? ram_rdata.raw : '0;
  assign coded_eff = sum_vld_r[addr_r] ? ram_rdata.coded : '0;

  assign lhs   = {coded_eff, {acs_pkg::LIM_W{1'b0}}};
  assign rhs   = (acs_pkg::PROD_W'(p_hi_r) << acs_pkg::SPLIT) + acs_pkg::PROD_W'(p_lo_r);
  assign below = lhs < rhs;
  assign walk_last = (acs_pkg::CCOUNT_W'(addr_r) + acs_pkg::CCOUNT_W'(1))
                     == acs_pkg::CCOUNT_W'(n_eff);

  always_comb begin
    state_nxt      = state_r;
    session_nxt    = session_r;
    sample_nxt     = sample_r;
    limit_nxt      = limit_r;
    colcnt_nxt     = colcnt_r;
    period_nxt     = period_r;
    phase_nxt      = phase_r;
    chunk_nxt      = chunk_r;
    lvl_vld_nxt    = lvl_vld_r;
    sum_vld_nxt    = sum_vld_r;
    addr_nxt       = addr_r;
    adj_nxt        = adj_r;
    out_valid_nxt  = out_valid_r;
    smp_raw_nxt    = smp_raw_r;
    smp_coded_nxt  = smp_coded_r;
    p_lo_nxt       = p_lo_r;
    p_hi_nxt       = p_hi_r;
    out_column_nxt = out_column_r;
    out_level_nxt  = out_level_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = addr_r;
    ram_raddr      = addr_r;
    ram_wdata      = '0;
    mod_req        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (mod_rsp.done) begin
      phase_nxt = mod_rsp.rem;
    end

    unique case (state_r)
      acs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == acs_pkg::CMD_CHUNK) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            addr_nxt  = '0;
            adj_nxt   = adj_now;
            chunk_nxt = chunk_r + acs_pkg::CC_W'(1);
            phase_nxt = ph_wrap;
            state_nxt = acs_pkg::S_MUL;
            if (adj_now && (period_r <= acs_pkg::PERIOD_CAP)) begin
              period_nxt       = period_r << 1;
              mod_req.start    = 1'b1;
              mod_req.dividend = chunk_r + acs_pkg::CC_W'(1);
              mod_req.divisor  = period_r << 1;
            end
          end else if (adapt_on && in_col_ok && in_window) begin
            ram_re        = 1'b1;
            ram_raddr     = in_column[acs_pkg::COL_W-1:0];
            addr_nxt      = in_column[acs_pkg::COL_W-1:0];
            smp_raw_nxt   = in_raw_bytes;
            smp_coded_nxt = in_coded_bytes;
            state_nxt     = acs_pkg::S_SAMP;
          end
        end
      end
      acs_pkg::S_SAMP: begin
        ram_we          = 1'b1;
        ram_wdata.level = lvl_eff;
        ram_wdata.raw   = acs_pkg::sat_add(raw_eff, smp_raw_r);
        ram_wdata.coded = acs_pkg::sat_add(coded_eff, smp_coded_r);
        lvl_vld_nxt[addr_r] = 1'b1;
        sum_vld_nxt[addr_r] = 1'b1;
        state_nxt       = acs_pkg::S_IDLE;
      end
      acs_pkg::S_MUL: begin
        p_lo_nxt  = acs_pkg::PLO_W'(raw_eff[acs_pkg::SPLIT-1:0]) * acs_pkg::PLO_W'(limit_r);
        p_hi_nxt  = acs_pkg::PHI_W'(raw_eff[acs_pkg::SUM_BITS-1:acs_pkg::SPLIT])
                    * acs_pkg::PHI_W'(limit_r);
        state_nxt = acs_pkg::S_OUT;
      end
      acs_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_column_nxt = acs_pkg::IN_COL_W'(addr_r);
          out_level_nxt  = lvl_eff;
          out_last_nxt   = walk_last;
          if (adj_r) begin
            ram_we          = 1'b1;
            ram_wdata.level = below ? session_r : '0;
            ram_wdata.raw   = '0;
            ram_wdata.coded = '0;
            lvl_vld_nxt[addr_r] = 1'b1;
            sum_vld_nxt[addr_r] = 1'b1;
          end
          if (walk_last) begin
            state_nxt = acs_pkg::S_IDLE;
          end else begin
            addr_nxt  = addr_r + acs_pkg::COL_W'(1);
            ram_re    = 1'b1;
            ram_raddr = addr_r + acs_pkg::COL_W'(1);
            state_nxt = acs_pkg::S_MUL;
          end
        end
      end
      default: begin
        state_nxt = acs_pkg::S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        acs_pkg::REG_SESSION_LEVEL: begin
          session_nxt = cfg_data[acs_pkg::LVL_W-1:0];
          lvl_vld_nxt = '0;
        end
        acs_pkg::REG_SAMPLE_COUNT: begin
          sample_nxt = cfg_data[acs_pkg::SMP_W-1:0];
        end
        acs_pkg::REG_RATIO_LIMIT: begin
          limit_nxt = cfg_data[acs_pkg::LIM_W-1:0];
        end
        acs_pkg::REG_INITIAL_PERIOD: begin
          period_nxt       = (cfg_data == '0) ? acs_pkg::PER_W'(1)
                                              : acs_pkg::PER_W'(cfg_data);
          mod_req.start    = 1'b1;
          mod_req.dividend = chunk_nxt;
          mod_req.divisor  = period_nxt;
        end
        acs_pkg::REG_COLUMN_COUNT: begin
          colcnt_nxt = cfg_data[acs_pkg::CCOUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acs_pkg::S_IDLE;
      session_r   <= acs_pkg::RST_SESSION;
      sample_r    <= acs_pkg::RST_SAMPLE;
      limit_r     <= acs_pkg::RST_LIMIT;
      colcnt_r    <= acs_pkg::RST_COLCOUNT;
      period_r    <= acs_pkg::RST_PERIOD;
      phase_r     <= '0;
      chunk_r     <= '0;
      lvl_vld_r   <= '0;
      sum_vld_r   <= '0;
      addr_r      <= '0;
      adj_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      session_r   <= session_nxt;
      sample_r    <= sample_nxt;
      limit_r     <= limit_nxt;
      colcnt_r    <= colcnt_nxt;
      period_r    <= period_nxt;
      phase_r     <= phase_nxt;
      chunk_r     <= chunk_nxt;
      lvl_vld_r   <= lvl_vld_nxt;
      sum_vld_r   <= sum_vld_nxt;
      addr_r      <= addr_nxt;
      adj_r       <= adj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_raw_r    <= smp_raw_nxt;
    smp_coded_r  <= smp_coded_nxt;
    p_lo_r       <= p_lo_nxt;
    p_hi_r       <= p_hi_nxt;
    out_column_r <= out_column_nxt;
    out_level_r  <= out_level_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_column = out_column_r;
  assign out_level  = out_level_r;
  assign out_last   = out_last_r;

  `ACS_ASSERT_IMPL(a_phase_range, clk, rst_n, !mod_rsp.busy, phase_r < period_r, "chunk phase not below period")
  `ACS_ASSERT_IMPL(a_last_column, clk, rst_n, out_valid_r && out_last_r, (acs_pkg::CCOUNT_W'(out_column_r) + acs_pkg::CCOUNT_W'(1)) == acs_pkg::CCOUNT_W'(n_eff), "last flag on wrong column")
  `ACS_ASSERT_IMPL(a_write_range, clk, rst_n, ram_we, acs_pkg::CCOUNT_W'(ram_waddr) < acs_pkg::CCOUNT_W'(n_eff), "entry write beyond columns in use")
  `ACS_ASSERT_NEXT(a_chunk_holds, clk, rst_n, in_acc && (in_cmd == acs_pkg::CMD_CHUNK), in_stall, "input taken during column walk")

endmodule

`default_nettype wire
